>>> src/vdh_pkg.sv
package vdh_pkg;

    localparam int NUM_ATTR  = 10;
    localparam int ATTR_W    = 32;
    localparam int DATA_W    = NUM_ATTR * ATTR_W;
    localparam int HASH_TERMS = 5;
    localparam int ACC_W     = 42;
    // Integer part of the magnitude of the hash sum: bits 41..16.
    localparam int DIV_W     = ACC_W - 16;
    localparam int OUT_IDX_W = 12;
    localparam int SLOT_CNT_W = 11;
    localparam int TOL_W     = 16;

    localparam logic CFG_SLOT_COUNT = 1'b0;
    localparam logic CFG_TOLERANCE  = 1'b1;

    localparam logic [SLOT_CNT_W-1:0] SLOT_COUNT_RESET = 11'd1024;
    localparam logic [TOL_W-1:0]      TOLERANCE_RESET  = 16'd66;

    typedef logic [6:0] weight_t;
    typedef logic [3:0] attr_sel_t;

    // Hash weights and the attributes they apply to: pos x, y, z, tex s, t.
    localparam weight_t   HASH_WEIGHT [HASH_TERMS] = '{7'd10, 7'd100, 7'd112, 7'd123, 7'd42};
    localparam attr_sel_t HASH_ATTR   [HASH_TERMS] = '{4'd0, 4'd1, 4'd2, 4'd6, 4'd7};

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_DIV,
        ST_FILL_RD,
        ST_FILL_WAIT,
        ST_SCAN,
        ST_CMP,
        ST_DECIDE,
        ST_OUT
    } state_t;

endpackage

>>> src/vdh_ram.sv
module vdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/vertex_dedup_hash_table.sv
// Vertex welding hash table.
//
// The slave stream carries one vertex per transaction: ten signed Q16.16
// attributes packed in tdata. For every vertex the block returns exactly one
// transaction on the master stream: the index of an equal stored vertex, or
// the newly assigned index with is_new set, or table_full when the bucket or
// the index space has no room (then nothing is stored).
//
// A vertex passes through hash accumulation (one weighted term per cycle
// through a single multiply-add unit), the modulo (a dividend load and 26
// restoring steps), a read of the bucket fill, a read and compare of each
// stored entry up to the first match, the end of the scan and the decision
// where none matches, and the posting of the result; the block then returns
// to idle before the next vertex can be taken. s_axis_tready is high only
// while the block is idle, so only one vertex is in flight.
// After reset the block clears the bucket fill memory, one slot per cycle,
// with s_axis_tready low; configuration writes are taken meanwhile. If the
// receiver stalls, the result waits in the output register; a following
// vertex is accepted and processed, but its result is held back until the
// previous one has been taken.
module vertex_dedup_hash_table #(
    parameter int MAX_SLOTS    = 1024,
    parameter int WAYS         = 4,
    parameter int MAX_VERTICES = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, tex_t, light_s, light_t
    input  logic [319:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // vertex_index[11:0], is_new[12], table_full[13], zero padding
    output logic [15:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [15:0]  cfg_wdata
);

    localparam int SLOT_W  = $clog2(MAX_SLOTS);
    localparam int NW      = $clog2(MAX_SLOTS + 1);
    localparam int REM_W   = NW + 1;
    localparam int FW      = $clog2(WAYS + 1);
    localparam int DEPTH   = MAX_SLOTS * WAYS;
    localparam int AW      = $clog2(DEPTH);
    localparam int IXW     = $clog2(MAX_VERTICES);
    localparam int NIW     = $clog2(MAX_VERTICES + 1);
    localparam int ENT_W   = IXW + vdh_pkg::DATA_W;
    localparam int DCW     = $clog2(vdh_pkg::DIV_W + 1);

    vdh_pkg::state_t state_reg, state_next;

    logic [vdh_pkg::SLOT_CNT_W-1:0] slot_count_reg;
    logic [vdh_pkg::TOL_W-1:0]      tol_reg;

    logic [vdh_pkg::DATA_W-1:0]     vtx_reg;
    logic signed [vdh_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [2:0]                     term_reg, term_next;
    logic [vdh_pkg::DIV_W-1:0]      dvd_reg, dvd_next;
    logic [REM_W-1:0]               rem_reg, rem_next;
    logic [DCW-1:0]                 dcnt_reg, dcnt_next;
    logic [NW-1:0]                  modn_reg, modn_next;
    logic [FW-1:0]                  fill_reg, fill_next;
    logic [FW-1:0]                  way_reg, way_next;
    logic [NIW-1:0]                 nidx_reg, nidx_next;
    logic [SLOT_W-1:0]              clr_reg, clr_next;

    logic [vdh_pkg::OUT_IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic                           res_new_reg, res_new_next;
    logic                           res_full_reg, res_full_next;
    logic                           ovalid_reg, ovalid_next;
    logic [15:0]                    odata_reg, odata_next;

    // Memory ports.
    logic              fill_we, fill_re;
    logic [SLOT_W-1:0] fill_waddr;
    logic [FW-1:0]     fill_wdata, fill_rdata;
    logic              ent_we, ent_re;
    logic [AW-1:0]     ent_addr;
    logic [ENT_W-1:0]  ent_wdata, ent_rdata;

    logic [SLOT_W-1:0] key;
    logic [AW-1:0]     slot_base;
    logic signed [39:0] term;
    logic [vdh_pkg::ACC_W-1:0] mag;
    logic [REM_W-1:0]  rem_shift;
    logic              all_close;
    logic [31:0]       idx_wide;

    vdh_ram #(.WIDTH(FW), .DEPTH(MAX_SLOTS)) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .re    (fill_re),
        .raddr (key),
        .rdata (fill_rdata)
    );

    vdh_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_addr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_addr),
        .rdata (ent_rdata)
    );

    assign s_axis_tready = (state_reg == vdh_pkg::ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    // The key is the final remainder of the serial division.
    assign key       = rem_reg[SLOT_W-1:0];
    assign slot_base = AW'(32'(key) * WAYS);

    // One weighted hash term per cycle.
    assign term = $signed(vtx_reg[vdh_pkg::HASH_ATTR[term_reg]*vdh_pkg::ATTR_W +: vdh_pkg::ATTR_W])
                * $signed({1'b0, vdh_pkg::HASH_WEIGHT[term_reg]});

    assign mag       = acc_reg[vdh_pkg::ACC_W-1] ? vdh_pkg::ACC_W'(-acc_reg) : acc_reg;
    assign rem_shift = {rem_reg[REM_W-2:0], dvd_reg[vdh_pkg::DIV_W-1]};

    // Every attribute of the stored entry within tolerance of the input.
    always_comb
    begin
        logic signed [32:0] diff;
        logic [32:0]        adiff;
        all_close = 1'b1;
        for (int i = 0; i < vdh_pkg::NUM_ATTR; i++)
        begin
            diff  = 33'($signed(ent_rdata[i*vdh_pkg::ATTR_W +: vdh_pkg::ATTR_W]))
                  - 33'($signed(vtx_reg[i*vdh_pkg::ATTR_W +: vdh_pkg::ATTR_W]));
            adiff = diff[32] ? 33'(-diff) : 33'(diff);
            if (!(adiff < {17'd0, tol_reg}))
            begin
                all_close = 1'b0;
            end
        end
    end

    assign idx_wide = 32'(ent_rdata[ENT_W-1 -: IXW]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= vdh_pkg::ST_CLEAR;
            slot_count_reg <= vdh_pkg::SLOT_COUNT_RESET;
            tol_reg        <= vdh_pkg::TOLERANCE_RESET;
            nidx_reg       <= '0;
            clr_reg        <= '0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            nidx_reg   <= nidx_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    vdh_pkg::CFG_SLOT_COUNT: slot_count_reg <= cfg_wdata[vdh_pkg::SLOT_CNT_W-1:0];
                    vdh_pkg::CFG_TOLERANCE:  tol_reg        <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            vtx_reg <= s_axis_tdata;
        end
        acc_reg      <= acc_next;
        term_reg     <= term_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dcnt_reg     <= dcnt_next;
        modn_reg     <= modn_next;
        fill_reg     <= fill_next;
        way_reg      <= way_next;
        res_idx_reg  <= res_idx_next;
        res_new_reg  <= res_new_next;
        res_full_reg <= res_full_next;
        odata_reg    <= odata_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        term_next     = term_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        dcnt_next     = dcnt_reg;
        modn_next     = modn_reg;
        fill_next     = fill_reg;
        way_next      = way_reg;
        nidx_next     = nidx_reg;
        clr_next      = clr_reg;
        res_idx_next  = res_idx_reg;
        res_new_next  = res_new_reg;
        res_full_next = res_full_reg;
        ovalid_next   = ovalid_reg;
        odata_next    = odata_reg;
        fill_we       = 1'b0;
        fill_re       = 1'b0;
        fill_waddr    = key;
        fill_wdata    = '0;
        ent_we        = 1'b0;
        ent_re        = 1'b0;
        ent_addr      = AW'(32'(slot_base) + 32'(way_reg));
        ent_wdata     = {nidx_reg[IXW-1:0], vtx_reg};

        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            vdh_pkg::ST_CLEAR:
            begin
                fill_we    = 1'b1;
                fill_waddr = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (32'(clr_reg) == MAX_SLOTS - 1)
                begin
                    state_next = vdh_pkg::ST_IDLE;
                end
            end
            vdh_pkg::ST_IDLE:
            begin
                acc_next  = '0;
                term_next = '0;
                // Effective modulus: zero acts as one, clamped to MAX_SLOTS.
                if (slot_count_reg == '0)
                begin
                    modn_next = NW'(1);
                end
                else if (32'(slot_count_reg) > MAX_SLOTS)
                begin
                    modn_next = NW'(MAX_SLOTS);
                end
                else
                begin
                    modn_next = NW'(slot_count_reg);
                end
                if (s_axis_tvalid)
                begin
                    state_next = vdh_pkg::ST_HASH;
                end
            end
            vdh_pkg::ST_HASH:
            begin
                acc_next  = acc_reg + vdh_pkg::ACC_W'(term);
                term_next = term_reg + 1'b1;
                if (32'(term_reg) == vdh_pkg::HASH_TERMS - 1)
                begin
                    state_next = vdh_pkg::ST_DIV;
                end
            end
            vdh_pkg::ST_DIV:
            begin
                if (term_reg != '0)
                begin
                    // First cycle of the division: load the dividend.
                    dvd_next  = mag[vdh_pkg::ACC_W-1:16];
                    rem_next  = '0;
                    dcnt_next = '0;
                    term_next = '0;
                end
                else
                begin
                    dvd_next  = {dvd_reg[vdh_pkg::DIV_W-2:0], 1'b0};
                    dcnt_next = dcnt_reg + 1'b1;
                    if (rem_shift >= REM_W'(modn_reg))
                    begin
                        rem_next = rem_shift - REM_W'(modn_reg);
                    end
                    else
                    begin
                        rem_next = rem_shift;
                    end
                    if (32'(dcnt_reg) == vdh_pkg::DIV_W - 1)
                    begin
                        state_next = vdh_pkg::ST_FILL_RD;
                    end
                end
            end
            vdh_pkg::ST_FILL_RD:
            begin
                fill_re    = 1'b1;
                state_next = vdh_pkg::ST_FILL_WAIT;
            end
            vdh_pkg::ST_FILL_WAIT:
            begin
                fill_next  = (32'(fill_rdata) > WAYS) ? FW'(WAYS) : fill_rdata;
                way_next   = '0;
                state_next = vdh_pkg::ST_SCAN;
            end
            vdh_pkg::ST_SCAN:
            begin
                if (way_reg < fill_reg)
                begin
                    ent_re     = 1'b1;
                    state_next = vdh_pkg::ST_CMP;
                end
                else
                begin
                    state_next = vdh_pkg::ST_DECIDE;
                end
            end
            vdh_pkg::ST_CMP:
            begin
                if (all_close)
                begin
                    res_idx_next  = idx_wide[vdh_pkg::OUT_IDX_W-1:0];
                    res_new_next  = 1'b0;
                    res_full_next = 1'b0;
                    state_next    = vdh_pkg::ST_OUT;
                end
                else
                begin
                    way_next   = way_reg + 1'b1;
                    state_next = vdh_pkg::ST_SCAN;
                end
            end
            vdh_pkg::ST_DECIDE:
            begin
                ent_addr = AW'(32'(slot_base) + 32'(fill_reg));
                if (32'(fill_reg) >= WAYS || 32'(nidx_reg) >= MAX_VERTICES)
                begin
                    res_idx_next  = '0;
                    res_new_next  = 1'b0;
                    res_full_next = 1'b1;
                end
                else
                begin
                    ent_we        = 1'b1;
                    fill_we       = 1'b1;
                    fill_wdata    = fill_reg + 1'b1;
                    res_idx_next  = vdh_pkg::OUT_IDX_W'(32'(nidx_reg));
                    res_new_next  = 1'b1;
                    res_full_next = 1'b0;
                    nidx_next     = nidx_reg + 1'b1;
                end
                state_next = vdh_pkg::ST_OUT;
            end
            vdh_pkg::ST_OUT:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {2'b00, res_full_reg, res_new_reg, res_idx_reg};
                    state_next  = vdh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vdh_pkg::ST_IDLE;
            end
        endcase
    end

    // A taken vertex blocks the input for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // A full table result never also claims a new vertex or a nonzero index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[13]) |-> (!m_axis_tdata[12] && m_axis_tdata[11:0] == '0))
        else $error("table_full result with is_new or index set");

    // The index counter never runs past the index space.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(nidx_reg) <= MAX_VERTICES)
        else $error("next index beyond MAX_VERTICES");

    // A pending result is not overwritten before it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("pending result lost");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

// Scoreboard for the vertex welding table. It keeps its own copy of the
// bucket memory and predicts the result of every vertex at the moment the
// vertex transaction is accepted.
class weld_scoreboard;
    typedef struct {
        logic [11:0] idx;
        bit          fresh;
        bit          full;
    } weld_result_t;

    int unsigned      slots_cfg;
    int unsigned      tol_cfg;
    int unsigned      fill [1024];
    int unsigned      next_idx;
    logic [31:0]      ent_attr [4096][10];
    int unsigned      ent_idx [4096];
    weld_result_t     pending_q [$];
    int unsigned      n_new;
    int unsigned      n_hit;
    int unsigned      n_full;

    function new();
        slots_cfg = vdh_pkg::SLOT_COUNT_RESET;
        tol_cfg   = vdh_pkg::TOLERANCE_RESET;
        next_idx  = 0;
        foreach (fill[i]) fill[i] = 0;
    endfunction

    function void set_reg(logic addr, logic [15:0] value);
        if (addr == vdh_pkg::CFG_SLOT_COUNT)
            slots_cfg = value[10:0];
        else
            tol_cfg = value;
    endfunction

    function int unsigned slot_of(logic [319:0] v);
        longint sum;
        longint mag;
        longint n;
        sum = 10  * longint'($signed(v[0*32 +: 32])) + 100 * longint'($signed(v[1*32 +: 32]))
            + 112 * longint'($signed(v[2*32 +: 32])) + 123 * longint'($signed(v[6*32 +: 32]))
            + 42  * longint'($signed(v[7*32 +: 32]));
        mag = (sum < 0) ? -sum : sum;
        n = slots_cfg;
        if (n == 0) n = 1;
        if (n > 1024) n = 1024;
        return int'((mag >>> 16) % n);
    endfunction

    function bit is_close(logic [31:0] a, logic [31:0] b);
        longint d;
        d = longint'($signed(a)) - longint'($signed(b));
        if (d < 0) d = -d;
        return d < longint'(tol_cfg);
    endfunction

    // Called for every accepted vertex transaction.
    function void note_vertex(logic [319:0] v);
        int unsigned  slot;
        int unsigned  e;
        bit           same;
        weld_result_t r;
        slot = slot_of(v);
        for (int w = 0; w < fill[slot]; w++) begin
            e = slot * 4 + w;
            same = 1;
            for (int i = 0; i < 10; i++)
                if (!is_close(ent_attr[e][i], v[i*32 +: 32])) same = 0;
            if (same) begin
                r.idx = ent_idx[e][11:0];
                r.fresh = 0;
                r.full = 0;
                pending_q.push_back(r);
                n_hit++;
                return;
            end
        end
        if (fill[slot] >= 4 || next_idx >= 4096) begin
            r.idx = '0;
            r.fresh = 0;
            r.full = 1;
            n_full++;
        end else begin
            e = slot * 4 + fill[slot];
            for (int i = 0; i < 10; i++) ent_attr[e][i] = v[i*32 +: 32];
            ent_idx[e] = next_idx;
            fill[slot]++;
            r.idx = next_idx[11:0];
            r.fresh = 1;
            r.full = 0;
            next_idx++;
            n_new++;
        end
        pending_q.push_back(r);
    endfunction

    // Compares one result transaction with the oldest prediction. Returns the
    // number of wrong fields and describes them in msg.
    function int check_result(logic [15:0] got, output string msg);
        weld_result_t r;
        int bad;
        bad = 0;
        msg = "";
        if (pending_q.size() == 0) begin
            msg = $sformatf("result %h arrived with no vertex outstanding", got);
            return 1;
        end
        r = pending_q.pop_front();
        if (got[11:0] !== r.idx) begin
            bad++;
            msg = {msg, $sformatf(" vertex_index %0d/%0d", got[11:0], r.idx)};
        end
        if (got[12] !== r.fresh) begin
            bad++;
            msg = {msg, $sformatf(" is_new %b/%b", got[12], r.fresh)};
        end
        if (got[13] !== r.full) begin
            bad++;
            msg = {msg, $sformatf(" table_full %b/%b", got[13], r.full)};
        end
        if (bad != 0) msg = {"got/expected:", msg};
        return bad;
    endfunction
endclass

module tb;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, tex_t, light_s, light_t
    logic [319:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // vertex_index[11:0], is_new[12], table_full[13], zero padding
    logic [15:0]  m_axis_tdata;
    logic         cfg_we;
    logic         cfg_addr;
    logic [15:0]  cfg_wdata;

    weld_scoreboard weld_sb;
    int             mismatches;
    int             results_seen;
    bit             idling_on;
    logic [319:0]   sent_pool [$];

    vertex_dedup_hash_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report(string msg);
        mismatches++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Both monitors sample the values from before the edge, so the order of
    // processes within the time step does not matter.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            weld_sb.note_vertex(s_axis_tdata);
    end

    always @(posedge clk)
    begin
        string msg;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (weld_sb.check_result(m_axis_tdata, msg) != 0) report(msg);
        end
    end

    function automatic int draw_gap();
        return idling_on ? $urandom_range(0, 14) : 0;
    endfunction

    // Receiver: a fresh stall is drawn for every result transaction.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // Presents one vertex and returns at the edge where it was taken; tvalid
    // stays high so a back-to-back vertex needs no second assignment.
    task automatic send_vertex(logic [319:0] v);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge clk); while (!s_axis_tready);
        sent_pool.push_back(v);
        if (sent_pool.size() > 64) void'(sent_pool.pop_front());
    endtask

    // The first edge lets the monitor note the last accepted vertex before
    // the outstanding count is looked at.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (weld_sb.pending_q.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // Only called while the table is idle.
    task automatic write_reg(logic addr, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        weld_sb.set_reg(addr, value);
        @(posedge clk);
    endtask

    function automatic logic [319:0] fill_all(logic [31:0] a);
        logic [319:0] v;
        for (int i = 0; i < 10; i++) v[i*32 +: 32] = a;
        return v;
    endfunction

    function automatic logic [319:0] rand_vertex();
        logic [319:0] v;
        for (int i = 0; i < 10; i++) v[i*32 +: 32] = $urandom;
        return v;
    endfunction

    // A stored vertex nudged by amounts around the tolerance, so that hits
    // and near misses both occur.
    function automatic logic [319:0] nudge(logic [319:0] v, int unsigned tol);
        int unsigned span;
        int          d;
        span = (tol == 0) ? 2 : tol + tol / 4 + 1;
        for (int i = 0; i < 10; i++) begin
            if ($urandom_range(0, 3) != 0) begin
                d = $urandom_range(0, span);
                if ($urandom_range(0, 1)) d = -d;
                v[i*32 +: 32] = v[i*32 +: 32] + d;
            end
        end
        return v;
    endfunction

    task automatic random_items(int count);
        logic [319:0] v;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 7))
                0, 1, 2, 3: begin
                    if (sent_pool.size() == 0) v = rand_vertex();
                    else v = nudge(sent_pool[$urandom_range(0, sent_pool.size() - 1)],
                                   weld_sb.tol_cfg);
                end
                4, 5: v = rand_vertex();
                default: begin
                    // Small positions spread over few keys to fill buckets.
                    v = rand_vertex();
                    v[0*32 +: 32] = $urandom_range(0, 32'h000F_FFFF);
                    v[1*32 +: 32] = 0;
                    v[2*32 +: 32] = 0;
                    v[6*32 +: 32] = 0;
                    v[7*32 +: 32] = 0;
                end
            endcase
            send_vertex(v);
        end
    endtask

    initial
    begin
        logic [319:0] v;
        logic [319:0] base_v;
        logic [15:0]  slot_settings [6];
        logic [15:0]  tol_settings [6];

        weld_sb       = new();
        mismatches    = 0;
        results_seen  = 0;
        idling_on     = 1;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_addr      = vdh_pkg::CFG_SLOT_COUNT;
        cfg_wdata     = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset settings: extremes, bit patterns and offsets just inside and at the tolerance.
        send_vertex(fill_all(32'h7FFF_FFFF));
        send_vertex(fill_all(32'h8000_0000));
        send_vertex(fill_all(32'h0000_0000));
        send_vertex(fill_all(32'hAAAA_AAAA));
        send_vertex(fill_all(32'h5555_5555));
        send_vertex(fill_all(32'hFFFF_FFFF));
        send_vertex(fill_all(32'h7FFF_FFFF));
        base_v = rand_vertex();
        send_vertex(base_v);
        v = base_v;
        v[5*32 +: 32] = v[5*32 +: 32] + 65;
        send_vertex(v);
        v[5*32 +: 32] = base_v[5*32 +: 32] - 66;
        send_vertex(v);

        // Pause until the table has answered everything sent so far.
        drain();

        // A single slot, already partly filled by the directed part: distinct vertices
        // are stored until the bucket is full and then refused, and a repeat hits only if it was stored.
        write_reg(vdh_pkg::CFG_SLOT_COUNT, 16'd1);
        for (int k = 0; k < 5; k++) send_vertex(fill_all(32'h0010_0000 * (k + 1)));
        send_vertex(fill_all(32'h0020_0000));
        drain();
        // Zero slot count behaves as one slot.
        write_reg(vdh_pkg::CFG_SLOT_COUNT, 16'd0);
        send_vertex(fill_all(32'h0030_0000));
        send_vertex(fill_all(32'h0123_0000));
        drain();
        // Zero tolerance: even an identical vertex is new.
        write_reg(vdh_pkg::CFG_SLOT_COUNT, 16'h07FF);
        write_reg(vdh_pkg::CFG_TOLERANCE, 16'd0);
        send_vertex(base_v);
        send_vertex(base_v);
        drain();
        write_reg(vdh_pkg::CFG_TOLERANCE, 16'hFFFF);
        send_vertex(nudge(base_v, 16'hFFFF));
        send_vertex(fill_all(32'h8000_0000));
        drain();

        // Random part, several register settings in turn.
        slot_settings = '{16'd1024, 16'd3, 16'h07FF, 16'd1, 16'd0, 16'd1024};
        tol_settings  = '{16'd66, 16'hFFFF, 16'd0, 16'd1000, 16'd66, 16'd66};
        for (int p = 0; p < 6; p++) begin
            write_reg(vdh_pkg::CFG_SLOT_COUNT, (p == 5) ? slot_settings[p]
                                               : $urandom_range(0, 1) ? slot_settings[p]
                                               : 16'($urandom_range(0, 16'hFFFF)));
            write_reg(vdh_pkg::CFG_TOLERANCE, tol_settings[p]);
            if (p == 2) begin
                idling_on = 0;
                random_items(60);
                idling_on = 1;
            end
            random_items(230);
            drain();
        end

        // One more miss and a repeat of an earlier vertex at full table size.
        write_reg(vdh_pkg::CFG_SLOT_COUNT, 16'd1024);
        write_reg(vdh_pkg::CFG_TOLERANCE, 16'd66);
        send_vertex(rand_vertex());
        send_vertex(sent_pool[0]);
        drain();

        repeat (100) @(posedge clk);
        $display("Covered %0d results: %0d new, %0d hits, %0d refused as full.",
                 results_seen, weld_sb.n_new, weld_sb.n_hit, weld_sb.n_full);
        $display("Slot counts 0 to 2047 and tolerances 0 to 65535 were exercised.");
        if (mismatches == 0 && weld_sb.pending_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("Timed out with %0d results outstanding.", weld_sb.pending_q.size());
        $display("Mismatches found");
        $finish;
    end
endmodule
